// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the timer table RTL.
// All checks are clocked on i_clk and are off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies another one at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ptt_pkg.sv -----
package ptt_pkg;

    // Table geometry
    localparam int NUM_SLOTS = 32;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int TIME_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int STAT_W    = 2;

    // Request codes
    typedef enum logic [FUNC_W-1:0] {
        F_TICK   = 2'd0,
        F_ADD    = 2'd1,
        F_ARM    = 2'd2,
        F_CANCEL = 2'd3
    } t_func;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_BUSY  = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_NOREG = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic op_en;    // request word accepted this cycle
        logic walk_en;  // tick walk in progress
        logic done_en;  // emit the end-of-tick word
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free; // output register can take a word this cycle
        logic walk_end; // every registered slot has been evaluated
    } t_sts;

endpackage

// ----- rtl/periodic_task_timer_table.sv -----
// Channel   Handshake                   Word fields
// request   i_in_valid / o_in_stall     i_func, i_slot, i_interval, i_repeat_req, i_now
// result    o_out_valid / i_out_stall   o_fired, o_slot_out, o_status, o_last
//
// For add, arm and cancel the answer sits in the output register the next cycle.
// A tick starts a walk: the first slot RAM read is started, each registered slot is evaluated
// in turn, the walk end is seen and the done word is registered; only then is the next
// request taken. Output stalls add cycles; requests stall while busy.
// Synchronous active-low reset clears armed flags, slot count, walk index and flag, output valid and
// sequencer; the slot RAM is not cleared (its data is used only for armed slots).
module periodic_task_timer_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ptt_pkg::FUNC_W-1:0]  i_func,
    input  logic [ptt_pkg::IDX_W-1:0]   i_slot,
    input  logic [ptt_pkg::TIME_W-1:0]  i_interval,
    input  logic                        i_repeat_req,
    input  logic [ptt_pkg::TIME_W-1:0]  i_now,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_fired,
    output logic [ptt_pkg::IDX_W-1:0]   o_slot_out,
    output logic [ptt_pkg::STAT_W-1:0]  o_status,
    output logic                        o_last
);

    import ptt_pkg::*;

    t_func   func;
    t_cmd    cmd;
    t_sts    sts;
    t_status status;

    assign func     = t_func'(i_func);
    assign o_status = status;

    // Sequencer
    ptt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (func),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Slot table, walk and output register
    ptt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (func),
        .i_slot       (i_slot),
        .i_interval   (i_interval),
        .i_repeat_req (i_repeat_req),
        .i_now        (i_now),
        .i_out_stall  (i_out_stall),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .o_fired      (o_fired),
        .o_slot_out   (o_slot_out),
        .o_status     (status),
        .o_last       (o_last)
    );

endmodule

// ----- rtl/ptt_ram.sv -----
module ptt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ptt_ctrl.sv -----
`include "assert_macros.svh"

module ptt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  ptt_pkg::t_func i_func,
    input  ptt_pkg::t_sts  i_sts,
    output logic           o_in_stall,
    output ptt_pkg::t_cmd  o_cmd
);

    import ptt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Requests are taken only when idle and the output register has room
    assign o_in_stall = !((r_state == S_IDLE) && i_sts.out_free);
    assign accept     = i_in_valid && !o_in_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_func == F_TICK)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.op_en = accept;
            end
            S_WALK: begin
                o_cmd.walk_en = 1'b1;
            end
            S_DONE: begin
                o_cmd.done_en = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_NEXT(a_tick_starts_walk, (accept && (i_func == F_TICK)), (r_state == S_WALK), "tick word did not start a walk")
    `ASSERT_ALWAYS(a_one_cmd, $onehot0({o_cmd.op_en, o_cmd.walk_en, o_cmd.done_en}), "more than one command active")

endmodule

// ----- rtl/ptt_dp.sv -----
`include "assert_macros.svh"

module ptt_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ptt_pkg::t_cmd               i_cmd,
    input  ptt_pkg::t_func              i_func,
    input  logic [ptt_pkg::IDX_W-1:0]   i_slot,
    input  logic [ptt_pkg::TIME_W-1:0]  i_interval,
    input  logic                        i_repeat_req,
    input  logic [ptt_pkg::TIME_W-1:0]  i_now,
    input  logic                        i_out_stall,
    output ptt_pkg::t_sts               o_sts,
    output logic                        o_out_valid,
    output logic                        o_fired,
    output logic [ptt_pkg::IDX_W-1:0]   o_slot_out,
    output ptt_pkg::t_status            o_status,
    output logic                        o_last
);

    import ptt_pkg::*;

    // Slot state
    logic [NUM_SLOTS-1:0] r_armed;
    logic [NUM_SLOTS-1:0] n_armed;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    // Walk state
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] n_now;
    logic [CNT_W-1:0]  r_rd_idx;
    logic [CNT_W-1:0]  n_rd_idx;
    logic              r_ev_vld;
    logic              n_ev_vld;
    logic [IDX_W-1:0]  r_ev_idx;
    logic [IDX_W-1:0]  n_ev_idx;

    // Output register
    logic             r_out_vld;
    logic             n_out_vld;
    logic             r_fired;
    logic             n_fired;
    logic [IDX_W-1:0] r_slot_out;
    logic [IDX_W-1:0] n_slot_out;
    t_status          r_status;
    t_status          n_status;
    logic             r_last;
    logic             n_last;

    // RAM port: {period, deadline}
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [2*TIME_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [2*TIME_W-1:0]   ram_rdata;

    logic [TIME_W-1:0] rd_deadline;
    logic [TIME_W-1:0] rd_period;
    logic [TIME_W-1:0] arm_deadline;
    logic [TIME_W-1:0] reload_deadline;
    logic              out_free;
    logic              hit;
    logic              advance;
    logic              slot_ok;
    logic              full;

    assign out_free        = !r_out_vld || !i_out_stall;
    assign rd_deadline     = ram_rdata[TIME_W-1:0];
    assign rd_period       = ram_rdata[2*TIME_W-1:TIME_W];
    assign arm_deadline    = i_now + i_interval;
    assign reload_deadline = r_now + rd_period;
    assign slot_ok         = CNT_W'(i_slot) < r_count;
    assign full            = r_count >= CNT_W'(NUM_SLOTS);

    // Walk evaluation: slot under test expired?
    assign hit     = i_cmd.walk_en && r_ev_vld && r_armed[r_ev_idx] && (r_now >= rd_deadline);
    assign advance = !(hit && !out_free);

    // Hold the read address on a stalled hit so the read data stays put
    assign ram_raddr = (i_cmd.walk_en && !advance) ? r_ev_idx : r_rd_idx[IDX_W-1:0];

    assign o_sts.out_free = out_free;
    assign o_sts.walk_end = !r_ev_vld && (r_rd_idx >= r_count);

    ptt_ram #(
        .WIDTH (2 * TIME_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next-state logic for slot table, walk and output word
    always_comb begin
        n_armed    = r_armed;
        n_count    = r_count;
        n_now      = r_now;
        n_rd_idx   = r_rd_idx;
        n_ev_vld   = r_ev_vld;
        n_ev_idx   = r_ev_idx;
        n_fired    = r_fired;
        n_slot_out = r_slot_out;
        n_status   = r_status;
        n_last     = r_last;
        n_out_vld  = r_out_vld && i_out_stall;
        ram_we     = 1'b0;
        ram_waddr  = r_ev_idx;
        ram_wdata  = {rd_period, reload_deadline};

        if (i_cmd.op_en) begin
            // Request words; all but tick answer at once
            n_fired = 1'b0;
            n_last  = 1'b1;
            case (i_func)
                F_TICK: begin
                    n_now    = i_now;
                    n_rd_idx = '0;
                    n_ev_vld = 1'b0;
                end
                F_ADD: begin
                    n_out_vld = 1'b1;
                    if (full) begin
                        n_slot_out = '0;
                        n_status   = STAT_FULL;
                    end else begin
                        n_armed[r_count[IDX_W-1:0]] = 1'b0;
                        n_slot_out = r_count[IDX_W-1:0];
                        n_status   = STAT_OK;
                        n_count    = r_count + CNT_W'(1);
                    end
                end
                F_ARM: begin
                    n_out_vld  = 1'b1;
                    n_slot_out = i_slot;
                    if (!slot_ok) begin
                        n_status = STAT_NOREG;
                    end else if (r_armed[i_slot]) begin
                        n_status = STAT_BUSY;
                    end else begin
                        n_status        = STAT_OK;
                        n_armed[i_slot] = 1'b1;
                        ram_we          = 1'b1;
                        ram_waddr       = i_slot;
                        ram_wdata       = {(i_repeat_req ? i_interval : '0), arm_deadline};
                    end
                end
                F_CANCEL: begin
                    n_out_vld  = 1'b1;
                    n_slot_out = i_slot;
                    if (!slot_ok) begin
                        n_status = STAT_NOREG;
                    end else begin
                        n_status        = STAT_OK;
                        n_armed[i_slot] = 1'b0;
                    end
                end
                default: begin
                    n_out_vld = r_out_vld && i_out_stall;
                end
            endcase
        end else if (i_cmd.walk_en) begin
            // One slot per cycle; a hit waits for room in the output register
            if (hit && out_free) begin
                n_out_vld  = 1'b1;
                n_fired    = 1'b1;
                n_slot_out = r_ev_idx;
                n_status   = STAT_OK;
                n_last     = 1'b0;
                if (rd_period == '0) begin
                    n_armed[r_ev_idx] = 1'b0;
                end else begin
                    ram_we = 1'b1;
                end
            end
            if (advance) begin
                n_ev_vld = r_rd_idx < r_count;
                n_ev_idx = r_rd_idx[IDX_W-1:0];
                if (r_rd_idx < r_count) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end
            end
        end else if (i_cmd.done_en) begin
            // End-of-tick word
            n_out_vld  = 1'b1;
            n_fired    = 1'b0;
            n_slot_out = '0;
            n_status   = STAT_OK;
            n_last     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= '0;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_ev_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_armed   <= n_armed;
            r_count   <= n_count;
            r_rd_idx  <= n_rd_idx;
            r_ev_vld  <= n_ev_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_ev_idx   <= n_ev_idx;
        r_fired    <= n_fired;
        r_slot_out <= n_slot_out;
        r_status   <= n_status;
        r_last     <= n_last;
    end

    assign o_out_valid = r_out_vld;
    assign o_fired     = r_fired;
    assign o_slot_out  = r_slot_out;
    assign o_status    = r_status;
    assign o_last      = r_last;

    `ASSERT_ALWAYS(a_count_range, (r_count <= CNT_W'(NUM_SLOTS)), "slot count beyond table size")
    `ASSERT_ALWAYS(a_walk_in_range, (r_ev_vld |-> (CNT_W'(r_ev_idx) < r_count)), "evaluated slot not registered")
    `ASSERT_ALWAYS(a_fired_not_last, ((r_out_vld && r_fired) |-> !r_last), "fired word marked last")

endmodule
